[rtl/egcd_pkg.sv]
// Package for the extended gcd core: data and coefficient widths,
// counter width and the sequencer state type.
// No dependencies.
package egcd_pkg;

    localparam int DATA_WIDTH = 31;
    localparam int COEF_WIDTH = DATA_WIDTH + 1;
    // Shift count reaches DATA_WIDTH-1 at most
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ALIGN  = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

endpackage

[rtl/extended_gcd_core.sv]
// Extended Euclidean gcd core: gcd and Bezout coefficients of two operands.
// Depends on egcd_pkg for widths and the sequencer state type.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  command  | i_start / o_busy     | i_operand_a, i_operand_b
//  result   | o_done (one cycle)   | o_gcd_value, o_coef_a, o_coef_b
//
// A command transfers when i_start is high and o_busy is low. Each Euclid
// step runs one shared shift-subtract divider: it aligns the divisor (k
// shifts and one compare that stops), then makes k+1 quotient bits
// (k = floor of log2 of the quotient), then updates the coefficients.
// An operand of zero goes straight to the result; for 31-bit operands
// neighbouring Fibonacci numbers give the longest runs. The core is
// ready again in the cycle after the result strobe.
// Synchronous active-low reset returns the sequencer to idle. The result
// is shown for one cycle and cannot be stalled by the receiver.
module extended_gcd_core
    import egcd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DATA_WIDTH-1:0]        i_operand_a,
    input  logic [DATA_WIDTH-1:0]        i_operand_b,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [DATA_WIDTH-1:0]        o_gcd_value,
    output logic signed [COEF_WIDTH-1:0] o_coef_a,
    output logic signed [COEF_WIDTH-1:0] o_coef_b
);

    t_state                r_state, n_state;
    logic [DATA_WIDTH-1:0] r_big, n_big;
    logic [DATA_WIDTH-1:0] r_small, n_small;
    logic [DATA_WIDTH-1:0] r_div, n_div;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [CNT_WIDTH-1:0]  r_cnt, n_cnt;
    logic [COEF_WIDTH-1:0] r_qs, n_qs;
    logic [COEF_WIDTH-1:0] r_qt, n_qt;
    logic [COEF_WIDTH-1:0] r_s_cur, n_s_cur;
    logic [COEF_WIDTH-1:0] r_s_prev, n_s_prev;
    logic [COEF_WIDTH-1:0] r_t_cur, n_t_cur;
    logic [COEF_WIDTH-1:0] r_t_prev, n_t_prev;
    logic                  r_exch, n_exch;

    logic                  accept;
    logic                  a_gt_b;
    logic [DATA_WIDTH:0]   div_x2;
    logic                  can_shift;
    logic                  qbit;

    assign accept    = i_start && !o_busy;
    assign a_gt_b    = i_operand_a > i_operand_b;
    assign div_x2    = {r_div, 1'b0};
    assign can_shift = div_x2 <= {1'b0, r_rem};
    assign qbit      = r_rem >= r_div;

    // Sequencer and shared divider datapath
    always_comb begin
        n_state  = r_state;
        n_big    = r_big;
        n_small  = r_small;
        n_div    = r_div;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_qs     = r_qs;
        n_qt     = r_qt;
        n_s_cur  = r_s_cur;
        n_s_prev = r_s_prev;
        n_t_cur  = r_t_cur;
        n_t_prev = r_t_prev;
        n_exch   = r_exch;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    // Larger operand is the first remainder
                    n_big    = a_gt_b ? i_operand_a : i_operand_b;
                    n_small  = a_gt_b ? i_operand_b : i_operand_a;
                    n_exch   = !a_gt_b;
                    n_s_prev = COEF_WIDTH'(1);
                    n_s_cur  = '0;
                    n_t_prev = '0;
                    n_t_cur  = COEF_WIDTH'(1);
                    n_div    = n_small;
                    n_rem    = n_big;
                    n_cnt    = '0;
                    n_qs     = '0;
                    n_qt     = '0;
                    n_state  = (n_small == '0) ? ST_FINISH : ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                // Shift the divisor up while it still fits under the remainder
                if (can_shift) begin
                    n_div = div_x2[DATA_WIDTH-1:0];
                    n_cnt = r_cnt + CNT_WIDTH'(1);
                end else begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                // One quotient bit; fold it into q*s and q*t at once
                if (qbit) begin
                    n_rem = r_rem - r_div;
                end
                n_qs = {r_qs[COEF_WIDTH-2:0], 1'b0} + (qbit ? r_s_cur : '0);
                n_qt = {r_qt[COEF_WIDTH-2:0], 1'b0} + (qbit ? r_t_cur : '0);
                if (r_cnt == '0) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_div = r_div >> 1;
                    n_cnt = r_cnt - CNT_WIDTH'(1);
                end
            end
            ST_UPDATE: begin
                // Advance the remainder pair and both coefficient tracks
                n_big    = r_small;
                n_small  = r_rem;
                n_s_prev = r_s_cur;
                n_s_cur  = r_s_prev - r_qs;
                n_t_prev = r_t_cur;
                n_t_cur  = r_t_prev - r_qt;
                n_div    = r_rem;
                n_rem    = r_small;
                n_cnt    = '0;
                n_qs     = '0;
                n_qt     = '0;
                n_state  = (r_rem == '0) ? ST_FINISH : ST_ALIGN;
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_big    <= n_big;
        r_small  <= n_small;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_qs     <= n_qs;
        r_qt     <= n_qt;
        r_s_cur  <= n_s_cur;
        r_s_prev <= n_s_prev;
        r_t_cur  <= n_t_cur;
        r_t_prev <= n_t_prev;
        r_exch   <= n_exch;
    end

    // Result: swap the coefficient tracks when a was not the larger operand
    assign o_busy      = r_state != ST_IDLE;
    assign o_done      = r_state == ST_FINISH;
    assign o_gcd_value = r_big;
    assign o_coef_a    = r_exch ? r_t_prev : r_s_prev;
    assign o_coef_b    = r_exch ? r_s_prev : r_t_prev;

    // Checks on the sequencer
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("command transfer did not make the core busy");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy && !o_done)
        else $error("result strobe not followed by idle");

    a_divide_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> ({1'b0, r_rem} < div_x2))
        else $error("partial remainder exceeds twice the divisor");

    a_done_zero_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_small == '0))
        else $error("result given before the remainder reached zero");

endmodule

[tb/tb_extended_gcd_core.sv]
// Self-checking testbench for extended_gcd_core: gcd and Bezout coefficient checks.
// Needs egcd_pkg and the extended_gcd_core RTL; the scoreboard class sits in this file.
`timescale 1ns / 100ps

// Scoreboard: predicts gcd and coefficients per accepted operand pair, checks results in order
class bezout_scoreboard;

    typedef struct packed {
        logic [egcd_pkg::DATA_WIDTH-1:0]        gcd_value;
        logic signed [egcd_pkg::COEF_WIDTH-1:0] coef_a;
        logic signed [egcd_pkg::COEF_WIDTH-1:0] coef_b;
    } t_bezout;

    t_bezout expected_results[$];
    int      mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    // Division-based Euclid; coefficient tracks wrap at 64 bits, low bits stay exact
    static function t_bezout solve_bezout(logic [egcd_pkg::DATA_WIDTH-1:0] a,
                                          logic [egcd_pkg::DATA_WIDTH-1:0] b);
        bit [63:0] big, rest, quot, rem, s_cur, s_prev, t_cur, t_prev, nxt;
        bit        swap_tracks;
        t_bezout   res;
        s_cur  = 64'd0;
        s_prev = 64'd1;
        t_cur  = 64'd1;
        t_prev = 64'd0;
        // larger operand opens as the first remainder
        if (a > b) begin
            big  = 64'(a);
            rest = 64'(b);
            swap_tracks = 1'b0;
        end else begin
            big  = 64'(b);
            rest = 64'(a);
            swap_tracks = 1'b1;
        end
        while (rest != 64'd0) begin
            quot = big / rest;
            rem  = big % rest;
            big  = rest;
            rest = rem;
            nxt    = s_prev - quot * s_cur;
            s_prev = s_cur;
            s_cur  = nxt;
            nxt    = t_prev - quot * t_cur;
            t_prev = t_cur;
            t_cur  = nxt;
        end
        // exchange tracks so coef_a always multiplies operand a
        if (swap_tracks) begin
            nxt    = s_prev;
            s_prev = t_prev;
            t_prev = nxt;
        end
        res.gcd_value = big[egcd_pkg::DATA_WIDTH-1:0];
        res.coef_a    = s_prev[egcd_pkg::COEF_WIDTH-1:0];
        res.coef_b    = t_prev[egcd_pkg::COEF_WIDTH-1:0];
        return res;
    endfunction

    function void note_operands(logic [egcd_pkg::DATA_WIDTH-1:0] a,
                                logic [egcd_pkg::DATA_WIDTH-1:0] b);
        expected_results.push_back(solve_bezout(a, b));
    endfunction

    function void check_result(logic [egcd_pkg::DATA_WIDTH-1:0]        gcd_value,
                               logic signed [egcd_pkg::COEF_WIDTH-1:0] coef_a,
                               logic signed [egcd_pkg::COEF_WIDTH-1:0] coef_b);
        t_bezout want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: gcd_value %0d coef_a %0d coef_b %0d",
                   gcd_value, coef_a, coef_b);
            mismatch_count++;
            return;
        end
        want = expected_results.pop_front();
        if (gcd_value !== want.gcd_value) begin
            $error("gcd_value mismatch: expected %0d, actual %0d", want.gcd_value, gcd_value);
            mismatch_count++;
        end
        if (coef_a !== want.coef_a) begin
            $error("coef_a mismatch: expected %0d, actual %0d", want.coef_a, coef_a);
            mismatch_count++;
        end
        if (coef_b !== want.coef_b) begin
            $error("coef_b mismatch: expected %0d, actual %0d", want.coef_b, coef_b);
            mismatch_count++;
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // Drop whatever is still owed and count each as a failure
    function void flush_leftovers();
        while (expected_results.size() != 0) begin
            t_bezout lost;
            lost = expected_results.pop_front();
            $error("missing result: gcd_value %0d coef_a %0d coef_b %0d",
                   lost.gcd_value, lost.coef_a, lost.coef_b);
            mismatch_count++;
        end
    endfunction

endclass

module tb_extended_gcd_core;
    import egcd_pkg::*;

    localparam int ITEMS_PER_PHASE = 370;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_start     = 1'b0;
    logic [DATA_WIDTH-1:0]        i_operand_a = '0;
    logic [DATA_WIDTH-1:0]        i_operand_b = '0;
    logic                         o_busy;
    logic                         o_done;
    logic [DATA_WIDTH-1:0]        o_gcd_value;
    logic signed [COEF_WIDTH-1:0] o_coef_a;
    logic signed [COEF_WIDTH-1:0] o_coef_b;

    bezout_scoreboard      board;
    int unsigned           idle_pct = 0;
    logic [DATA_WIDTH-1:0] fib[0:46];

    extended_gcd_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_gcd_value (o_gcd_value),
        .o_coef_a    (o_coef_a),
        .o_coef_b    (o_coef_b)
    );

    always #4 i_clk = ~i_clk;

    // Monitor: check results first, then note a command transfer on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) board.check_result(o_gcd_value, o_coef_a, o_coef_b);
            if (i_start && !o_busy) board.note_operands(i_operand_a, i_operand_b);
        end
    end

    // Issue one operand pair; hold start high from the previous transfer unless idling
    task automatic send_operands(input logic [DATA_WIDTH-1:0] a,
                                 input logic [DATA_WIDTH-1:0] b);
        int unsigned gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap = ($urandom_range(15) == 0) ? $urandom_range(2, 300) : $urandom_range(1, 4);
            i_start     <= 1'b0;
            i_operand_a <= DATA_WIDTH'($urandom);
            i_operand_b <= DATA_WIDTH'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Random pair drawn from a mix of shapes that stress different step counts
    task automatic send_random_pair();
        logic [DATA_WIDTH-1:0] a, b, g, x, y;
        int unsigned           len, glen, k;
        a = DATA_WIDTH'($urandom);
        b = DATA_WIDTH'($urandom);
        case ($urandom_range(9))
            4: begin
                len = $urandom_range(1, DATA_WIDTH);
                a = a & DATA_WIDTH'((64'd1 << len) - 1);
                len = $urandom_range(1, DATA_WIDTH);
                b = b & DATA_WIDTH'((64'd1 << len) - 1);
            end
            5: begin
                // shared factor so the gcd is large
                glen = $urandom_range(1, 24);
                g = DATA_WIDTH'($urandom_range(1, (1 << glen) - 1));
                x = DATA_WIDTH'($urandom) & DATA_WIDTH'((64'd1 << (DATA_WIDTH - glen)) - 1);
                y = DATA_WIDTH'($urandom) & DATA_WIDTH'((64'd1 << (DATA_WIDTH - glen)) - 1);
                a = DATA_WIDTH'(g * x);
                b = DATA_WIDTH'(g * y);
            end
            6: begin
                if ($urandom_range(1) == 0) a = '0;
                else b = '0;
            end
            7: b = a;
            8: begin
                // neighbouring Fibonacci numbers give the longest Euclid runs
                k = $urandom_range(1, 45);
                a = fib[k + 1];
                b = fib[k];
                if ($urandom_range(1) == 0) begin
                    a = fib[k];
                    b = fib[k + 1];
                end
            end
            9: begin
                a = DATA_WIDTH'($urandom_range(15));
                b = DATA_WIDTH'($urandom_range(15));
            end
            default: ;
        endcase
        send_operands(a, b);
    endtask

    // Generous fixed limit on the whole run
    initial begin
        #20_000_000;
        $display("FAIL extended_gcd_core");
        $finish;
    end

    initial begin
        int unsigned phase_pct[4];
        int unsigned wait_cycles;
        logic [DATA_WIDTH-1:0] all_ones;
        board = new();
        all_ones = '1;
        fib[0] = '0;
        fib[1] = DATA_WIDTH'(1);
        for (int n = 2; n <= 46; n++) fib[n] = fib[n - 1] + fib[n - 2];
        phase_pct[0] = 0;
        phase_pct[1] = 55;
        phase_pct[2] = 0;
        phase_pct[3] = 37;

        // hold reset low, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: zeros, equal, extremes, longest chains, bit patterns
        send_operands('0, '0);
        send_operands(all_ones, '0);
        send_operands('0, all_ones);
        send_operands(DATA_WIDTH'(1), '0);
        send_operands('0, DATA_WIDTH'(1));
        send_operands(DATA_WIDTH'(1), DATA_WIDTH'(1));
        send_operands(all_ones, all_ones);
        send_operands(all_ones, DATA_WIDTH'(1));
        send_operands(DATA_WIDTH'(1), all_ones);
        send_operands(all_ones, DATA_WIDTH'(all_ones - 1));
        send_operands(DATA_WIDTH'(all_ones - 1), all_ones);
        send_operands(fib[46], fib[45]);
        send_operands(fib[45], fib[46]);
        send_operands(DATA_WIDTH'(31'h4000_0000), DATA_WIDTH'(31'h2000_0000));
        send_operands(DATA_WIDTH'(31'h2AAA_AAAA), DATA_WIDTH'(31'h5555_5555));
        send_operands(DATA_WIDTH'(31'h5555_5555), DATA_WIDTH'(31'h2AAA_AAAA));
        send_operands(DATA_WIDTH'(240), DATA_WIDTH'(46));
        send_operands(DATA_WIDTH'(46), DATA_WIDTH'(240));
        send_operands(DATA_WIDTH'(12345), DATA_WIDTH'(12345));
        send_operands(DATA_WIDTH'(2), DATA_WIDTH'(3));
        send_operands(all_ones, DATA_WIDTH'(31'h4000_0000));

        // random phases with differing idle rates, stretches of no idling inside each
        for (int ph = 0; ph < 4; ph++) begin
            for (int seg = 0; seg < ITEMS_PER_PHASE / 37; seg++) begin
                idle_pct = ($urandom_range(3) == 0) ? 0 : phase_pct[ph];
                repeat (37) send_random_pair();
            end
        end
        i_start <= 1'b0;

        // drain, then watch a while for stray results
        wait_cycles = 0;
        while (board.pending() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (400) @(posedge i_clk);
        board.flush_leftovers();

        if (board.mismatch_count == 0) begin
            $display("PASS extended_gcd_core");
        end else begin
            $display("FAIL extended_gcd_core");
        end
        $finish;
    end

endmodule
